// ===== rtl/tbtg_pkg.sv =====
package tbtg_pkg;

    localparam int CLOCK_W    = 26;
    localparam int BAND_W     = 16;
    localparam int FREQ_W     = 16;
    localparam int PIN_W      = 5;
    localparam int VEC_W      = 16;
    localparam int PIN_IDX_W  = 4;
    localparam int PIN_COUNT  = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int QUEUE_DEPTH = 4;

    localparam int WIDE_N   = 5;
    localparam int NARROW_N = 4;
    localparam logic [3:0] WIDE_SHIFT [WIDE_N]     = '{4'd0, 4'd3, 4'd6, 4'd8, 4'd10};
    localparam logic [3:0] NARROW_SHIFT [NARROW_N] = '{4'd0, 4'd3, 4'd5, 4'd6};
    // quotient must lie in 1 .. max compare + 1
    localparam logic [CLOCK_W-1:0] WIDE_Q_MAX   = 26'd65536;
    localparam logic [CLOCK_W-1:0] NARROW_Q_MAX = 26'd256;

    localparam logic [CLOCK_W-1:0] CLOCK_RESET = 26'd16000000;
    localparam logic [BAND_W-1:0]  BAND_RESET  = 16'd500;

    localparam logic [1:0] CMD_TICK = 2'd0;
    localparam logic [1:0] CMD_PLAY = 2'd1;
    localparam logic [1:0] CMD_STOP = 2'd2;

    localparam logic [1:0] STATUS_OK      = 2'd0;
    localparam logic [1:0] STATUS_BAD_PIN = 2'd1;
    localparam logic [1:0] STATUS_LOW     = 2'd2;
    localparam logic [1:0] STATUS_ZERO    = 2'd3;

    localparam logic [1:0] CH_NONE   = 2'd0;
    localparam logic [1:0] CH_WIDE   = 2'd1;
    localparam logic [1:0] CH_NARROW = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_CLOCK_HZ   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BAND_LIMIT = 2'd1;

    typedef enum logic [1:0] {
        OP_TICK,
        OP_PLAY,
        OP_STOP,
        OP_NOP
    } op_t;

    typedef struct packed {
        logic [1:0]        command;
        logic [PIN_W-1:0]  pin;
        logic [FREQ_W-1:0] frequency;
    } item_t;

    typedef struct packed {
        logic [VEC_W-1:0]  pin_levels;
        logic [VEC_W-1:0]  pin_outputs;
        logic [1:0]        status;
        logic [1:0]        channel_used;
        logic [10:0]       prescale_used;
        logic [15:0]       compare_used;
    } res_t;

    typedef struct packed {
        op_t                   op;
        logic [PIN_IDX_W-1:0]  pin;
        logic [FREQ_W-1:0]     freq;
        logic [1:0]            status;
    } entry_t;

endpackage

// ===== rtl/two_band_tone_generator.sv =====
// Two-channel square-wave tone generator driven by a stream of tick, play and stop
// words, one result word per input word. A front stage classifies each word and
// checks the pin and zero frequency, then parks it in a four-entry queue; the back
// stage executes words in order. Tick, stop and rejected play words are finished in the
// back stage's run state, so ticks sustain one per cycle while the result side keeps
// up. A play word that passes the front checks waits in the divide state for the 26-step
// bit-serial divider that forms clock_hz / (2 * frequency); the prescaler and compare
// value then follow from shifts of that quotient. The queue keeps accepting words, as long
// as it has room, while a play is being divided.
module two_band_tone_generator (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_valid,
    output logic                             s_ready,
    input  tbtg_pkg::item_t                  s_data,
    output logic                             m_valid,
    input  logic                             m_ready,
    output tbtg_pkg::res_t                   m_data,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [tbtg_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [tbtg_pkg::CLOCK_W-1:0]     cfg_data
);

    logic [tbtg_pkg::CLOCK_W-1:0] clock_hz_reg;
    logic [tbtg_pkg::BAND_W-1:0]  band_limit_reg;
    logic                         q_valid, q_pop;
    tbtg_pkg::entry_t             q_entry;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clock_hz_reg   <= tbtg_pkg::CLOCK_RESET;
            band_limit_reg <= tbtg_pkg::BAND_RESET;
        end else if (cfg_valid) begin
            case (cfg_index)
                tbtg_pkg::CFG_CLOCK_HZ:   clock_hz_reg   <= cfg_data;
                tbtg_pkg::CFG_BAND_LIMIT: band_limit_reg <= cfg_data[tbtg_pkg::BAND_W-1:0];
                default: ;
            endcase
        end
    end

    tbtg_front u_front (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .q_valid (q_valid),
        .q_entry (q_entry),
        .q_pop   (q_pop)
    );

    tbtg_back u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .clock_hz      (clock_hz_reg),
        .band_limit_hz (band_limit_reg),
        .q_valid       (q_valid),
        .q_entry       (q_entry),
        .q_pop         (q_pop),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_data        (m_data)
    );

endmodule

// ===== rtl/tbtg_front.sv =====
module tbtg_front (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  tbtg_pkg::item_t   s_data,
    output logic              q_valid,
    output tbtg_pkg::entry_t  q_entry,
    input  logic              q_pop
);

    localparam int PTR_W = $clog2(tbtg_pkg::QUEUE_DEPTH);
    localparam int CNT_W = $clog2(tbtg_pkg::QUEUE_DEPTH + 1);

    tbtg_pkg::entry_t queue_reg [tbtg_pkg::QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    tbtg_pkg::entry_t entry_in;
    logic push, pop;

    // classify the word on the way in; pin and zero checks need no state
    always_comb begin
        entry_in.pin    = s_data.pin[tbtg_pkg::PIN_IDX_W-1:0];
        entry_in.freq   = s_data.frequency;
        entry_in.status = tbtg_pkg::STATUS_OK;
        case (s_data.command)
            tbtg_pkg::CMD_TICK: entry_in.op = tbtg_pkg::OP_TICK;
            tbtg_pkg::CMD_PLAY: entry_in.op = tbtg_pkg::OP_PLAY;
            tbtg_pkg::CMD_STOP: entry_in.op = tbtg_pkg::OP_STOP;
            default:            entry_in.op = tbtg_pkg::OP_NOP;
        endcase
        if (6'(s_data.pin) >= 6'(tbtg_pkg::PIN_COUNT) ||
            6'(s_data.pin) >= 6'(tbtg_pkg::VEC_W)) begin
            entry_in.status = tbtg_pkg::STATUS_BAD_PIN;
        end else if (s_data.frequency == '0) begin
            entry_in.status = tbtg_pkg::STATUS_ZERO;
        end
    end

    assign s_ready = (count_reg != CNT_W'(tbtg_pkg::QUEUE_DEPTH));
    assign push    = s_valid && s_ready;
    assign q_valid = (count_reg != '0);
    assign pop     = q_pop && q_valid;
    assign q_entry = queue_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (push) begin
            queue_reg[wr_ptr_reg] <= entry_in;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + PTR_W'(1);
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + PTR_W'(1);
            end
            case ({push, pop})
                2'b10:   count_reg <= count_reg + CNT_W'(1);
                2'b01:   count_reg <= count_reg - CNT_W'(1);
                default: count_reg <= count_reg;
            endcase
        end
    end

endmodule

// ===== rtl/tbtg_div.sv =====
module tbtg_div (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          start,
    input  logic [tbtg_pkg::CLOCK_W-1:0]  dividend,
    input  logic [tbtg_pkg::FREQ_W:0]     divisor,
    output logic                          done,
    output logic [tbtg_pkg::CLOCK_W-1:0]  quotient
);

    localparam int DW = tbtg_pkg::FREQ_W + 1;

    logic                          busy_reg, done_reg;
    logic [4:0]                    step_reg;
    logic [tbtg_pkg::CLOCK_W-1:0]  quo_reg;
    logic [DW-1:0]                 rem_reg, dvs_reg;
    logic [DW:0]                   rem_shift, diff;

    // restoring division, one quotient bit per cycle
    assign rem_shift = {rem_reg, quo_reg[tbtg_pkg::CLOCK_W-1]};
    assign diff      = rem_shift - {1'b0, dvs_reg};
    assign done      = done_reg;
    assign quotient  = quo_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end else if (start) begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            step_reg <= '0;
        end else if (busy_reg) begin
            step_reg <= step_reg + 5'd1;
            if (step_reg == 5'(tbtg_pkg::CLOCK_W - 1)) begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            quo_reg <= dividend;
            rem_reg <= '0;
            dvs_reg <= divisor;
        end else if (busy_reg) begin
            if (!diff[DW]) begin
                rem_reg <= diff[DW-1:0];
                quo_reg <= {quo_reg[tbtg_pkg::CLOCK_W-2:0], 1'b1};
            end else begin
                rem_reg <= rem_shift[DW-1:0];
                quo_reg <= {quo_reg[tbtg_pkg::CLOCK_W-2:0], 1'b0};
            end
        end
    end

endmodule

// ===== rtl/tbtg_back.sv =====
module tbtg_back (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic [tbtg_pkg::CLOCK_W-1:0]  clock_hz,
    input  logic [tbtg_pkg::BAND_W-1:0]   band_limit_hz,
    input  logic                          q_valid,
    input  tbtg_pkg::entry_t              q_entry,
    output logic                          q_pop,
    output logic                          m_valid,
    input  logic                          m_ready,
    output tbtg_pkg::res_t                m_data
);

    typedef enum logic {
        ST_RUN,
        ST_DIV
    } state_t;

    state_t state_reg, state_next;

    logic        wide_active_reg, wide_active_next;
    logic [3:0]  wide_pin_reg, wide_pin_next;
    logic [10:0] wide_prescale_reg, wide_prescale_next;
    logic [15:0] wide_compare_reg, wide_compare_next;
    logic [9:0]  wide_pcount_reg, wide_pcount_next;
    logic [15:0] wide_count_reg, wide_count_next;
    logic        narrow_active_reg, narrow_active_next;
    logic [3:0]  narrow_pin_reg, narrow_pin_next;
    logic [6:0]  narrow_prescale_reg, narrow_prescale_next;
    logic [7:0]  narrow_compare_reg, narrow_compare_next;
    logic [5:0]  narrow_pcount_reg, narrow_pcount_next;
    logic [7:0]  narrow_count_reg, narrow_count_next;
    logic [15:0] level_reg, level_next;
    logic [15:0] dir_reg, dir_next;
    logic [3:0]  pin_reg, pin_next;
    logic [15:0] freq_reg, freq_next;
    logic        out_valid_reg, out_valid_next;
    tbtg_pkg::res_t out_data_reg, out_data_next;

    logic        div_start, div_done;
    logic [tbtg_pkg::CLOCK_W-1:0] div_q;

    tbtg_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (clock_hz),
        .divisor  ({q_entry.freq, 1'b0}),
        .done     (div_done),
        .quotient (div_q)
    );

    assign m_valid = out_valid_reg;
    assign m_data  = out_data_reg;

    always_comb begin
        logic        out_free, load;
        logic [10:0] w_pc_inc;
        logic [6:0]  n_pc_inc;
        logic        w_wrap, n_wrap, w_flip, n_flip;
        logic [15:0] flip;
        logic [tbtg_pkg::CLOCK_W-1:0] qs;
        logic        w_found, n_found;
        logic [10:0] w_ps;
        logic [6:0]  n_ps;
        logic [15:0] w_cmp;
        logic [7:0]  n_cmp;

        state_next           = state_reg;
        wide_active_next     = wide_active_reg;
        wide_pin_next        = wide_pin_reg;
        wide_prescale_next   = wide_prescale_reg;
        wide_compare_next    = wide_compare_reg;
        wide_pcount_next     = wide_pcount_reg;
        wide_count_next      = wide_count_reg;
        narrow_active_next   = narrow_active_reg;
        narrow_pin_next      = narrow_pin_reg;
        narrow_prescale_next = narrow_prescale_reg;
        narrow_compare_next  = narrow_compare_reg;
        narrow_pcount_next   = narrow_pcount_reg;
        narrow_count_next    = narrow_count_reg;
        level_next           = level_reg;
        dir_next             = dir_reg;
        pin_next             = pin_reg;
        freq_next            = freq_reg;
        out_data_next        = out_data_reg;
        q_pop                = 1'b0;
        div_start            = 1'b0;
        load                 = 1'b0;

        out_free       = !out_valid_reg || m_ready;
        out_valid_next = out_valid_reg && !m_ready;

        // one clock of both channels
        w_pc_inc = {1'b0, wide_pcount_reg} + 11'd1;
        n_pc_inc = {1'b0, narrow_pcount_reg} + 7'd1;
        w_wrap   = (w_pc_inc >= wide_prescale_reg);
        n_wrap   = (n_pc_inc >= narrow_prescale_reg);
        w_flip   = wide_active_reg && w_wrap && (wide_count_reg >= wide_compare_reg);
        n_flip   = narrow_active_reg && n_wrap && (narrow_count_reg >= narrow_compare_reg);
        flip     = (w_flip ? (16'd1 << wide_pin_reg) : 16'd0) ^
                   (n_flip ? (16'd1 << narrow_pin_reg) : 16'd0);

        // smallest prescaler whose quotient fits, lowest index wins
        w_found = 1'b0;
        w_ps    = '0;
        w_cmp   = '0;
        for (int i = tbtg_pkg::WIDE_N - 1; i >= 0; i--) begin
            qs = div_q >> tbtg_pkg::WIDE_SHIFT[i];
            if (qs != '0 && qs <= tbtg_pkg::WIDE_Q_MAX) begin
                w_found = 1'b1;
                w_ps    = 11'd1 << tbtg_pkg::WIDE_SHIFT[i];
                w_cmp   = 16'(qs - 26'd1);
            end
        end
        n_found = 1'b0;
        n_ps    = '0;
        n_cmp   = '0;
        for (int i = tbtg_pkg::NARROW_N - 1; i >= 0; i--) begin
            qs = div_q >> tbtg_pkg::NARROW_SHIFT[i];
            if (qs != '0 && qs <= tbtg_pkg::NARROW_Q_MAX) begin
                n_found = 1'b1;
                n_ps    = 7'd1 << tbtg_pkg::NARROW_SHIFT[i];
                n_cmp   = 8'(qs - 26'd1);
            end
        end

        case (state_reg)
            ST_RUN: begin
                if (q_valid && out_free) begin
                    q_pop                       = 1'b1;
                    out_data_next.status        = tbtg_pkg::STATUS_OK;
                    out_data_next.channel_used  = tbtg_pkg::CH_NONE;
                    out_data_next.prescale_used = '0;
                    out_data_next.compare_used  = '0;
                    case (q_entry.op)
                        tbtg_pkg::OP_TICK: begin
                            load = 1'b1;
                            if (wide_active_reg) begin
                                if (w_wrap) begin
                                    wide_pcount_next = '0;
                                    wide_count_next  = (wide_count_reg >= wide_compare_reg) ?
                                                       16'd0 : wide_count_reg + 16'd1;
                                end else begin
                                    wide_pcount_next = w_pc_inc[9:0];
                                end
                            end
                            if (narrow_active_reg) begin
                                if (n_wrap) begin
                                    narrow_pcount_next = '0;
                                    narrow_count_next  =
                                        (narrow_count_reg >= narrow_compare_reg) ?
                                        8'd0 : narrow_count_reg + 8'd1;
                                end else begin
                                    narrow_pcount_next = n_pc_inc[5:0];
                                end
                            end
                            level_next = level_reg ^ flip;
                        end
                        tbtg_pkg::OP_PLAY: begin
                            if (q_entry.status != tbtg_pkg::STATUS_OK) begin
                                load                 = 1'b1;
                                out_data_next.status = q_entry.status;
                            end else begin
                                div_start  = 1'b1;
                                pin_next   = q_entry.pin;
                                freq_next  = q_entry.freq;
                                state_next = ST_DIV;
                            end
                        end
                        tbtg_pkg::OP_STOP: begin
                            load = 1'b1;
                            level_next = level_reg &
                                ~(wide_active_reg ? (16'd1 << wide_pin_reg) : 16'd0) &
                                ~(narrow_active_reg ? (16'd1 << narrow_pin_reg) : 16'd0);
                            wide_active_next     = 1'b0;
                            wide_pin_next        = '0;
                            wide_prescale_next   = '0;
                            wide_compare_next    = '0;
                            wide_pcount_next     = '0;
                            wide_count_next      = '0;
                            narrow_active_next   = 1'b0;
                            narrow_pin_next      = '0;
                            narrow_prescale_next = '0;
                            narrow_compare_next  = '0;
                            narrow_pcount_next   = '0;
                            narrow_count_next    = '0;
                        end
                        default: begin
                            load = 1'b1;
                        end
                    endcase
                end
            end
            ST_DIV: begin
                if (div_done && out_free) begin
                    load                        = 1'b1;
                    state_next                  = ST_RUN;
                    out_data_next.status        = tbtg_pkg::STATUS_LOW;
                    out_data_next.channel_used  = tbtg_pkg::CH_NONE;
                    out_data_next.prescale_used = '0;
                    out_data_next.compare_used  = '0;
                    if (freq_reg < band_limit_hz) begin
                        if (w_found) begin
                            wide_active_next            = 1'b1;
                            wide_pin_next               = pin_reg;
                            wide_prescale_next          = w_ps;
                            wide_compare_next           = w_cmp;
                            wide_pcount_next            = '0;
                            wide_count_next             = '0;
                            dir_next                    = dir_reg | (16'd1 << pin_reg);
                            out_data_next.status        = tbtg_pkg::STATUS_OK;
                            out_data_next.channel_used  = tbtg_pkg::CH_WIDE;
                            out_data_next.prescale_used = w_ps;
                            out_data_next.compare_used  = w_cmp;
                        end
                    end else begin
                        if (n_found) begin
                            narrow_active_next          = 1'b1;
                            narrow_pin_next             = pin_reg;
                            narrow_prescale_next        = n_ps;
                            narrow_compare_next         = n_cmp;
                            narrow_pcount_next          = '0;
                            narrow_count_next           = '0;
                            dir_next                    = dir_reg | (16'd1 << pin_reg);
                            out_data_next.status        = tbtg_pkg::STATUS_OK;
                            out_data_next.channel_used  = tbtg_pkg::CH_NARROW;
                            out_data_next.prescale_used = 11'(n_ps);
                            out_data_next.compare_used  = 16'(n_cmp);
                        end
                    end
                end
            end
            default: begin
                state_next = ST_RUN;
            end
        endcase

        if (load) begin
            out_valid_next            = 1'b1;
            out_data_next.pin_levels  = level_next;
            out_data_next.pin_outputs = dir_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg           <= ST_RUN;
            wide_active_reg     <= 1'b0;
            wide_pin_reg        <= '0;
            wide_prescale_reg   <= '0;
            wide_compare_reg    <= '0;
            wide_pcount_reg     <= '0;
            wide_count_reg      <= '0;
            narrow_active_reg   <= 1'b0;
            narrow_pin_reg      <= '0;
            narrow_prescale_reg <= '0;
            narrow_compare_reg  <= '0;
            narrow_pcount_reg   <= '0;
            narrow_count_reg    <= '0;
            level_reg           <= '0;
            dir_reg             <= '0;
            out_valid_reg       <= 1'b0;
        end else begin
            state_reg           <= state_next;
            wide_active_reg     <= wide_active_next;
            wide_pin_reg        <= wide_pin_next;
            wide_prescale_reg   <= wide_prescale_next;
            wide_compare_reg    <= wide_compare_next;
            wide_pcount_reg     <= wide_pcount_next;
            wide_count_reg      <= wide_count_next;
            narrow_active_reg   <= narrow_active_next;
            narrow_pin_reg      <= narrow_pin_next;
            narrow_prescale_reg <= narrow_prescale_next;
            narrow_compare_reg  <= narrow_compare_next;
            narrow_pcount_reg   <= narrow_pcount_next;
            narrow_count_reg    <= narrow_count_next;
            level_reg           <= level_next;
            dir_reg             <= dir_next;
            out_valid_reg       <= out_valid_next;
        end
        pin_reg      <= pin_next;
        freq_reg     <= freq_next;
        out_data_reg <= out_data_next;
    end

endmodule

// ===== tb/sv/tb.sv =====
`timescale 1ns / 1ps

module tb;
    import tbtg_pkg::*;

    localparam int LIMIT_CYCLES = 400000;
    localparam int SETTLE_CYCLES = 40;
    localparam int PRINT_CAP = 100;
    localparam logic [1:0] CMD_NOP = OP_NOP;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = 2'd3;

    logic aclk = 1'b0;
    logic aresetn;
    logic s_valid;
    logic s_ready;
    item_t s_data;
    logic m_valid;
    logic m_ready = 1'b0;
    res_t m_data;
    logic cfg_valid;
    logic cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CLOCK_W-1:0] cfg_data;

    two_band_tone_generator uut (
        .aclk(aclk),
        .aresetn(aresetn),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .s_data(s_data),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_data(m_data),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    always #10 aclk = ~aclk;

    // tone model state
    logic [CLOCK_W-1:0] clk_rate;
    logic [BAND_W-1:0] band_edge;
    bit wide_on, narrow_on;
    logic [PIN_IDX_W-1:0] wide_pin, narrow_pin;
    int unsigned wide_ps, wide_cmp, wide_pcnt, wide_cnt;
    int unsigned narrow_ps, narrow_cmp, narrow_pcnt, narrow_cnt;
    logic [VEC_W-1:0] levels, pin_dirs;

    res_t due_words[$];
    int errors = 0;
    int words_seen = 0;
    int cycles = 0;
    int send_idle_pct = 0;
    int stall_pct = 0;
    int hold_left = 0;

    task automatic clear_tones();
        wide_on = 0; wide_pin = '0; wide_ps = 0; wide_cmp = 0; wide_pcnt = 0; wide_cnt = 0;
        narrow_on = 0; narrow_pin = '0; narrow_ps = 0; narrow_cmp = 0;
        narrow_pcnt = 0; narrow_cnt = 0;
    endtask

    // smallest prescaler whose quotient fits the channel's compare range
    task automatic pick_divider(input bit wide, input int unsigned freq, output bit ok,
                                output int unsigned ps, output int unsigned cmp);
        int n;
        int i;
        int unsigned scale;
        longint unsigned q;
        longint unsigned q_max;
        ok = 0; ps = 0; cmp = 0;
        n = wide ? WIDE_N : NARROW_N;
        q_max = wide ? 64'(WIDE_Q_MAX) : 64'(NARROW_Q_MAX);
        for (i = 0; i < n && !ok; i++) begin
            if (wide) scale = 1 << WIDE_SHIFT[i];
            else scale = 1 << NARROW_SHIFT[i];
            q = longint'(clk_rate) / (longint'(scale) * 2 * longint'(freq));
            if (q >= 1 && q <= q_max) begin
                ok = 1;
                ps = scale;
                cmp = 32'(q - 1);
            end
        end
    endtask

    task automatic advance_channel(input int unsigned ps, input int unsigned cmp,
                                   input int unsigned pmask, inout int unsigned pcnt,
                                   inout int unsigned cnt, output bit flip);
        flip = 0;
        if (pcnt + 1 >= ps) begin
            pcnt = 0;
            if (cnt >= cmp) begin
                cnt = 0;
                flip = 1;
            end else begin
                cnt = (cnt + 1) & 32'hFFFF;
            end
        end else begin
            pcnt = (pcnt + 1) & pmask;
        end
    endtask

    task automatic predict_tone_word(input item_t w, output res_t r);
        bit flip_w, flip_n, ok, wide;
        int unsigned ps, cmp;
        logic [1:0] st, ch;
        logic [VEC_W-1:0] flips;
        ps = 0; cmp = 0; st = STATUS_OK; ch = CH_NONE; flips = '0;
        case (w.command)
            CMD_TICK: begin
                if (wide_on) begin
                    advance_channel(wide_ps, wide_cmp, 32'h3FF, wide_pcnt, wide_cnt, flip_w);
                    if (flip_w) flips[wide_pin] = ~flips[wide_pin];
                end
                if (narrow_on) begin
                    advance_channel(narrow_ps, narrow_cmp, 32'h3F, narrow_pcnt, narrow_cnt,
                                    flip_n);
                    // toggles on a shared pin cancel
                    if (flip_n) flips[narrow_pin] = ~flips[narrow_pin];
                end
                levels ^= flips;
            end
            CMD_PLAY: begin
                if (w.pin >= PIN_COUNT || w.pin >= VEC_W) begin
                    st = STATUS_BAD_PIN;
                end else if (w.frequency == 0) begin
                    st = STATUS_ZERO;
                end else begin
                    wide = w.frequency < band_edge;
                    pick_divider(wide, 32'(w.frequency), ok, ps, cmp);
                    if (!ok) begin
                        st = STATUS_LOW;
                        ps = 0;
                        cmp = 0;
                    end else if (wide) begin
                        wide_on = 1; wide_pin = w.pin[PIN_IDX_W-1:0];
                        wide_ps = ps; wide_cmp = cmp; wide_pcnt = 0; wide_cnt = 0;
                        ch = CH_WIDE;
                    end else begin
                        narrow_on = 1; narrow_pin = w.pin[PIN_IDX_W-1:0];
                        narrow_ps = ps; narrow_cmp = cmp; narrow_pcnt = 0; narrow_cnt = 0;
                        ch = CH_NARROW;
                    end
                    if (ok) pin_dirs[w.pin[PIN_IDX_W-1:0]] = 1'b1;
                end
            end
            CMD_STOP: begin
                if (wide_on) levels[wide_pin] = 1'b0;
                if (narrow_on) levels[narrow_pin] = 1'b0;
                clear_tones();
            end
            default: begin
            end
        endcase
        r.pin_levels = levels;
        r.pin_outputs = pin_dirs;
        r.status = st;
        r.channel_used = ch;
        r.prescale_used = ps[10:0];
        r.compare_used = cmp[15:0];
    endtask

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        errors++;
        if (errors <= PRINT_CAP)
            $display("mismatch in %s at word %0d: got %0h, want %0h",
                     what, words_seen, got, want);
    endtask

    task automatic check_field(input string name, input logic [31:0] got,
                               input logic [31:0] want);
        if (got !== want) report_mismatch(name, got, want);
    endtask

    always @(posedge aclk) begin
        res_t want;
        if (aresetn && m_valid && m_ready) begin
            if (due_words.size() == 0) begin
                report_mismatch("unexpected word", 32'(m_data.status), 32'd0);
            end else begin
                want = due_words.pop_front();
                check_field("pin_levels", 32'(m_data.pin_levels), 32'(want.pin_levels));
                check_field("pin_outputs", 32'(m_data.pin_outputs), 32'(want.pin_outputs));
                check_field("status", 32'(m_data.status), 32'(want.status));
                check_field("channel_used", 32'(m_data.channel_used),
                            32'(want.channel_used));
                check_field("prescale_used", 32'(m_data.prescale_used),
                            32'(want.prescale_used));
                check_field("compare_used", 32'(m_data.compare_used),
                            32'(want.compare_used));
            end
            words_seen++;
        end
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT_CYCLES) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // result side: long hold-off when requested, else random stalls
    always @(negedge aclk) begin
        if (hold_left > 0) begin
            m_ready <= 1'b0;
            hold_left = hold_left - 1;
        end else begin
            m_ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    task automatic send_word(input item_t w);
        res_t want;
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_data <= w;
        do @(posedge aclk); while (!s_ready);
        predict_tone_word(w, want);
        due_words.push_back(want);
        @(negedge aclk);
    endtask

    // drop valid, wait out every expected word and any play still in flight
    task automatic wait_idle();
        s_valid <= 1'b0;
        while (due_words.size() != 0) @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CLOCK_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do @(posedge aclk); while (!cfg_ready);
        if (idx == CFG_CLOCK_HZ) clk_rate = val;
        else if (idx == CFG_BAND_LIMIT) band_edge = val[BAND_W-1:0];
        @(negedge aclk);
        cfg_valid <= 1'b0;
        @(negedge aclk);
    endtask

    function automatic item_t make_word(input logic [1:0] cmd, input logic [PIN_W-1:0] p,
                                        input logic [FREQ_W-1:0] f);
        item_t w;
        w.command = cmd;
        w.pin = p;
        w.frequency = f;
        return w;
    endfunction

    function automatic item_t random_word();
        int roll;
        item_t w;
        roll = $urandom_range(99);
        if (roll < 75) w.command = CMD_TICK;
        else if (roll < 90) w.command = CMD_PLAY;
        else if (roll < 95) w.command = CMD_STOP;
        else w.command = CMD_NOP;
        w.pin = ($urandom_range(99) < 80) ? 5'($urandom_range(PIN_COUNT - 1)) :
                                            5'($urandom_range(31));
        roll = $urandom_range(99);
        if (roll < 50) w.frequency = 16'($urandom_range(40, 1));
        else if (roll < 92) w.frequency = 16'($urandom_range(16'hFFFF));
        else w.frequency = '0;
        return w;
    endfunction

    task automatic test_directed();
        // reset settings: bad pins, zero frequency, both bands, band edge
        send_word(make_word(CMD_TICK, 5'd0, 16'd0));
        send_word(make_word(CMD_NOP, 5'd31, 16'hFFFF));
        send_word(make_word(CMD_STOP, 5'd0, 16'd0));
        send_word(make_word(CMD_PLAY, 5'd16, 16'd1000));
        send_word(make_word(CMD_PLAY, 5'd31, 16'd0));
        send_word(make_word(CMD_PLAY, 5'd3, 16'd0));
        send_word(make_word(CMD_PLAY, 5'd0, 16'd1));
        send_word(make_word(CMD_PLAY, 5'd15, 16'hFFFF));
        send_word(make_word(CMD_PLAY, 5'd4, 16'd499));
        send_word(make_word(CMD_PLAY, 5'd6, 16'd500));
        send_word(make_word(CMD_TICK, 5'd0, 16'd0));
        send_word(make_word(CMD_STOP, 5'd0, 16'd0));
        wait_idle();
        // clock too slow for any divider
        write_reg(CFG_CLOCK_HZ, 26'd1);
        write_reg(CFG_SPARE_A, 26'h3FFFFFF);
        write_reg(CFG_SPARE_B, 26'h2AAAAAA);
        send_word(make_word(CMD_PLAY, 5'd1, 16'd1));
        send_word(make_word(CMD_PLAY, 5'd1, 16'hFFFF));
        wait_idle();
        // both channels on one pin; they toggle together on the fourth tick
        write_reg(CFG_CLOCK_HZ, 26'd8);
        write_reg(CFG_BAND_LIMIT, 26'd2);
        send_word(make_word(CMD_PLAY, 5'd5, 16'd1));
        send_word(make_word(CMD_PLAY, 5'd5, 16'd2));
        repeat (4) send_word(make_word(CMD_TICK, 5'd0, 16'd0));
        send_word(make_word(CMD_STOP, 5'd0, 16'd0));
        wait_idle();
        // narrow channel too low, then a larger narrow prescaler
        write_reg(CFG_CLOCK_HZ, 26'd64000000);
        write_reg(CFG_BAND_LIMIT, 26'd1);
        send_word(make_word(CMD_PLAY, 5'd7, 16'd1));
        send_word(make_word(CMD_PLAY, 5'd7, 16'hFFFF));
        wait_idle();
    endtask

    task automatic test_backpressure();
        send_idle_pct = 0;
        stall_pct = 0;
        write_reg(CFG_CLOCK_HZ, 26'd60);
        write_reg(CFG_BAND_LIMIT, 26'd4);
        hold_left = 300;
        send_word(make_word(CMD_PLAY, 5'd9, 16'd2));
        send_word(make_word(CMD_PLAY, 5'd10, 16'd6));
        repeat (40) send_word(make_word(CMD_TICK, 5'd0, 16'd0));
        wait_idle();
    endtask

    task automatic apply_setting(input int k);
        case (k)
            0: begin
                write_reg(CFG_CLOCK_HZ, 26'($urandom_range(400, 8)));
                write_reg(CFG_BAND_LIMIT, 26'($urandom_range(40, 2)));
            end
            1: begin
                write_reg(CFG_CLOCK_HZ, 26'd64000000);
                write_reg(CFG_BAND_LIMIT, 26'd65535);
            end
            2: begin
                write_reg(CFG_CLOCK_HZ, 26'($urandom_range(64000000, 1)));
                write_reg(CFG_BAND_LIMIT, 26'($urandom_range(65535, 1)));
            end
            3: begin
                write_reg(CFG_CLOCK_HZ, 26'd1);
                write_reg(CFG_BAND_LIMIT, 26'd1);
            end
            4: begin
                write_reg(CFG_CLOCK_HZ, 26'($urandom_range(400, 8)));
                write_reg(CFG_BAND_LIMIT, 26'd1);
            end
            default: begin
                write_reg(CFG_CLOCK_HZ, 26'($urandom_range(3000, 100)));
                write_reg(CFG_BAND_LIMIT, 26'd65535);
            end
        endcase
    endtask

    task automatic test_random();
        int phase;
        int s;
        int n;
        for (phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin send_idle_pct = 0; stall_pct = 0; end
                1: begin send_idle_pct = 82; stall_pct = 0; end
                2: begin send_idle_pct = 0; stall_pct = 82; end
                default: begin send_idle_pct = 13; stall_pct = 13; end
            endcase
            for (s = 0; s < 3; s++) begin
                apply_setting((phase * 3 + s) % 6);
                for (n = 0; n < 160; n++) send_word(random_word());
                wait_idle();
            end
        end
    endtask

    initial begin
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_data = '0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        clk_rate = CLOCK_RESET;
        band_edge = BAND_RESET;
        levels = '0;
        pin_dirs = '0;
        clear_tones();
        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        test_directed();
        test_backpressure();
        test_random();
        wait_idle();

        if (errors == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

// ===== files.f =====
rtl/tbtg_pkg.sv
rtl/tbtg_front.sv
rtl/tbtg_div.sv
rtl/tbtg_back.sv
rtl/two_band_tone_generator.sv
tb/sv/tb.sv
